/* src/ptts_pkg.sv */
// Shared types, constants and helpers for the polyline to triangle strip extruder.
// Used by ptts_ctrl, ptts_dp and polyline_to_triangle_strip; depends on nothing else.
`timescale 1ns / 1ps

package ptts_pkg;

    // Defaults for the top-level parameters.
    localparam int FRAC_BITS_DEF    = 16;
    localparam int CORDIC_STEPS_DEF = 16;

    // Field and port widths.
    localparam int COORD_W   = 32;
    localparam int COLOR_W   = 32;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_THICKNESS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR     = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [CFG_W-1:0] THICKNESS_RST = 32'd65536;
    localparam logic [CFG_W-1:0] COLOR_RST     = 32'd255;

    // Inverse CORDIC gain in Q0.32.
    localparam logic [31:0] KINV_Q32 = 32'd2608131496;

    // The segment vector is doubled until its larger component reaches 2^NORM_LOG2.
    localparam int NORM_LOG2 = 40;
    // Width of the segment difference, of the normalized vector and of a rounded offset.
    localparam int DIFF_W = COORD_W + 1;
    localparam int VEC_W  = 45;
    localparam int OFF_W  = 34;

    localparam logic signed [OFF_W:0] SAT_MAX = (OFF_W+1)'(32'sh7FFF_FFFF);
    localparam logic signed [OFF_W:0] SAT_MIN = (OFF_W+1)'(32'sh8000_0000);

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic                      last_point;
    } point_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] vertex_x;
        logic signed [COORD_W-1:0] vertex_y;
        logic [COLOR_W-1:0]        color_out;
        logic                      side;
        logic                      last_vertex;
    } vertex_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_NORM,
        S_ROT,
        S_ROUND,
        S_LOAD,
        S_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic setup;
        logic norm;
        logic rot;
        logic round;
        logic out_load;
    } ptts_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic start;
        logic zero_seg;
        logic norm_done;
        logic rot_last;
        logic out_done;
    } ptts_status_t;

    // Clamp a vertex sum to the signed 32-bit range.
    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [OFF_W:0] v);
        logic signed [COORD_W-1:0] r;
        if (v > SAT_MAX)
        begin
            r = SAT_MAX[COORD_W-1:0];
        end
        else if (v < SAT_MIN)
        begin
            r = SAT_MIN[COORD_W-1:0];
        end
        else
        begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

/* src/ptts_ctrl.sv */
// Sequencing state machine of the polyline extruder.
// Depends on ptts_pkg; drives ptts_dp through command and status structs.
`timescale 1ns / 1ps

module ptts_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  ptts_pkg::ptts_status_t status,
    output ptts_pkg::ptts_cmd_t    cmd
);
    import ptts_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (status.start)
                    begin
                        state_next = S_SETUP;
                    end
                end
            end
            S_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = status.zero_seg ? S_LOAD : S_NORM;
            end
            S_NORM:
            begin
                if (status.norm_done)
                begin
                    state_next = S_ROT;
                end
                else
                begin
                    cmd.norm = 1'b1;
                end
            end
            S_ROT:
            begin
                cmd.rot = 1'b1;
                if (status.rot_last)
                begin
                    state_next = S_ROUND;
                end
            end
            S_ROUND:
            begin
                cmd.round  = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                cmd.out_load = 1'b1;
                state_next   = S_EMIT;
            end
            S_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (status.out_done)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.out_load = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* src/ptts_dp.sv */
// Datapath of the polyline extruder: held point, configuration, normalizer,
// iterative CORDIC, offset rounding and the vertex output register. Depends on ptts_pkg.
`timescale 1ns / 1ps

module ptts_dp #(
    parameter int FRAC_BITS    = ptts_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = ptts_pkg::CORDIC_STEPS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [ptts_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ptts_pkg::CFG_W-1:0]     cfg_data,
    input  ptts_pkg::point_t               in_data,
    output ptts_pkg::vertex_t              out_data,
    input  ptts_pkg::ptts_cmd_t            cmd,
    output ptts_pkg::ptts_status_t         status
);
    import ptts_pkg::*;

    localparam int CW  = FRAC_BITS + 34;
    localparam int SW  = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam int PSH = 33 - FRAC_BITS;

    localparam logic [SW-1:0] STEP_LAST = SW'(CORDIC_STEPS - 1);
    localparam logic signed [CW-1:0] HALF_LSB = CW'(64'd1 << (FRAC_BITS - 1));

    // A vector whose larger component is below LIMn may still be shifted by n bits.
    // LIM1 is the normalization target itself: below it one more doubling is due.
    localparam logic signed [VEC_W-1:0] LIM8 = VEC_W'(64'd1 << (NORM_LOG2 - 8));
    localparam logic signed [VEC_W-1:0] LIM4 = VEC_W'(64'd1 << (NORM_LOG2 - 4));
    localparam logic signed [VEC_W-1:0] LIM2 = VEC_W'(64'd1 << (NORM_LOG2 - 2));
    localparam logic signed [VEC_W-1:0] LIM1 = VEC_W'(64'd1 << NORM_LOG2);

    // Configuration.
    logic [CFG_W-1:0] thickness_reg;
    logic [CFG_W-1:0] color_reg;

    // Held point.
    logic signed [COORD_W-1:0] held_x_reg;
    logic signed [COORD_W-1:0] held_y_reg;
    logic                      have_held_reg;

    // Per-request context.
    logic signed [COORD_W-1:0] pa_x_reg;
    logic signed [COORD_W-1:0] pa_y_reg;
    logic signed [COORD_W-1:0] pb_x_reg;
    logic signed [COORD_W-1:0] pb_y_reg;
    logic                      four_reg;
    logic                      fin_reg;
    logic                      zero_reg;
    logic signed [DIFF_W-1:0]  dx_reg;
    logic signed [DIFF_W-1:0]  dy_reg;
    logic [63:0]               prod_reg;

    // CORDIC state.
    logic signed [VEC_W-1:0] x_reg;
    logic signed [VEC_W-1:0] y_reg;
    logic signed [CW-1:0]    cx_reg;
    logic signed [CW-1:0]    cy_reg;
    logic [SW-1:0]           step_reg;

    // Rounded offsets and output.
    logic signed [OFF_W-1:0] tx_reg;
    logic signed [OFF_W-1:0] ty_reg;
    logic [1:0]              vidx_reg;
    vertex_t                 out_reg;
    logic                    out_done_reg;

    logic signed [DIFF_W-1:0] dx_next;
    logic signed [DIFF_W-1:0] dy_next;
    logic                     fit8;
    logic                     fit4;
    logic                     fit2;
    logic                     fit1;
    logic [CW-1:0]            cmag;
    logic                     neg;
    logic signed [VEC_W-1:0]  xs;
    logic signed [VEC_W-1:0]  ys;
    logic signed [CW-1:0]     cxs;
    logic signed [CW-1:0]     cys;
    logic signed [CW-1:0]     rnd;
    logic                     v_pair;
    logic                     v_side;
    logic signed [OFF_W:0]    vpx;
    logic signed [OFF_W:0]    vpy;
    logic signed [OFF_W:0]    vtx;
    logic signed [OFF_W:0]    vty;
    logic                     v_end;

    always_comb
    begin
        dx_next = DIFF_W'(in_data.point_x) - DIFF_W'(held_x_reg);
        dy_next = DIFF_W'(in_data.point_y) - DIFF_W'(held_y_reg);

        fit8 = (x_reg < LIM8) && (y_reg < LIM8) && (y_reg > -LIM8);
        fit4 = (x_reg < LIM4) && (y_reg < LIM4) && (y_reg > -LIM4);
        fit2 = (x_reg < LIM2) && (y_reg < LIM2) && (y_reg > -LIM2);
        fit1 = (x_reg < LIM1) && (y_reg < LIM1) && (y_reg > -LIM1);

        cmag = CW'(prod_reg >> PSH);
        neg  = dx_reg[DIFF_W-1];

        xs  = x_reg >>> step_reg;
        ys  = y_reg >>> step_reg;
        cxs = cx_reg >>> step_reg;
        cys = cy_reg >>> step_reg;

        rnd = cy_reg + HALF_LSB;

        v_pair = vidx_reg[1];
        v_side = vidx_reg[0];
        vpx    = (OFF_W+1)'(v_pair ? pb_x_reg : pa_x_reg);
        vpy    = (OFF_W+1)'(v_pair ? pb_y_reg : pa_y_reg);
        vtx    = (OFF_W+1)'(tx_reg);
        vty    = (OFF_W+1)'(ty_reg);
        v_end  = v_side && (v_pair || !four_reg);

        status.start     = have_held_reg || in_data.last_point;
        status.zero_seg  = zero_reg;
        status.norm_done = !fit1;
        status.rot_last  = (step_reg == STEP_LAST);
        status.out_done  = out_done_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thickness_reg <= THICKNESS_RST;
            color_reg     <= COLOR_RST;
            held_x_reg    <= '0;
            held_y_reg    <= '0;
            have_held_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_THICKNESS: thickness_reg <= cfg_data;
                    CFG_COLOR:     color_reg     <= cfg_data;
                    default:       ;
                endcase
            end
            if (cmd.accept)
            begin
                if (have_held_reg && in_data.last_point)
                begin
                    have_held_reg <= 1'b0;
                    held_x_reg    <= '0;
                    held_y_reg    <= '0;
                end
                else if (!in_data.last_point)
                begin
                    have_held_reg <= 1'b1;
                    held_x_reg    <= in_data.point_x;
                    held_y_reg    <= in_data.point_y;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            pa_x_reg <= have_held_reg ? held_x_reg : in_data.point_x;
            pa_y_reg <= have_held_reg ? held_y_reg : in_data.point_y;
            pb_x_reg <= in_data.point_x;
            pb_y_reg <= in_data.point_y;
            four_reg <= have_held_reg && in_data.last_point;
            fin_reg  <= in_data.last_point;
            dx_reg   <= dx_next;
            dy_reg   <= dy_next;
            zero_reg <= !have_held_reg || ((dx_next == '0) && (dy_next == '0));
            prod_reg <= 64'(thickness_reg) * 64'(KINV_Q32);
            vidx_reg <= 2'd0;
        end

        if (cmd.setup)
        begin
            step_reg <= '0;
            cy_reg   <= '0;
            x_reg    <= neg ? -VEC_W'(dx_reg) : VEC_W'(dx_reg);
            y_reg    <= neg ? -VEC_W'(dy_reg) : VEC_W'(dy_reg);
            cx_reg   <= neg ? -$signed(cmag) : $signed(cmag);
            if (zero_reg)
            begin
                tx_reg <= '0;
                ty_reg <= OFF_W'(({1'b0, thickness_reg} + 33'd1) >> 1);
            end
        end

        if (cmd.norm)
        begin
            if (fit8)
            begin
                x_reg <= x_reg <<< 8;
                y_reg <= y_reg <<< 8;
            end
            else if (fit4)
            begin
                x_reg <= x_reg <<< 4;
                y_reg <= y_reg <<< 4;
            end
            else if (fit2)
            begin
                x_reg <= x_reg <<< 2;
                y_reg <= y_reg <<< 2;
            end
            else
            begin
                x_reg <= x_reg <<< 1;
                y_reg <= y_reg <<< 1;
            end
        end

        if (cmd.rot)
        begin
            step_reg <= step_reg + SW'(1);
            if (!y_reg[VEC_W-1])
            begin
                x_reg  <= x_reg + ys;
                y_reg  <= y_reg - xs;
                cx_reg <= cx_reg - cys;
                cy_reg <= cy_reg + cxs;
            end
            else
            begin
                x_reg  <= x_reg - ys;
                y_reg  <= y_reg + xs;
                cx_reg <= cx_reg + cys;
                cy_reg <= cy_reg - cxs;
            end
        end

        if (cmd.round)
        begin
            tx_reg <= OFF_W'(rnd >>> FRAC_BITS);
            ty_reg <= OFF_W'((cx_reg + HALF_LSB) >>> FRAC_BITS);
        end

        if (cmd.out_load)
        begin
            vidx_reg              <= vidx_reg + 2'd1;
            out_reg.vertex_x      <= sat32(v_side ? (vpx - vtx) : (vpx + vtx));
            out_reg.vertex_y      <= sat32(v_side ? (vpy + vty) : (vpy - vty));
            out_reg.color_out     <= color_reg;
            out_reg.side          <= v_side;
            out_reg.last_vertex   <= v_end && fin_reg;
            out_done_reg          <= v_end;
        end
    end

    assign out_data = out_reg;

endmodule

/* src/polyline_to_triangle_strip.sv */
// Top level of the polyline to triangle strip extruder.
// Depends on ptts_pkg, ptts_ctrl and ptts_dp.
`timescale 1ns / 1ps

// Polyline points (signed Q16.16) arrive as requests on the input channel and
// leave as triangle strip vertices on the output channel. A point without
// last_point is held and produces nothing; each later point yields two vertices
// for the held point, offset by half the thickness perpendicular to the
// segment, and a final point adds its own pair reusing that offset. A lone
// final point, or a zero-length segment, uses the offset (0, half thickness).
// The block works on one request at a time: after acceptance it sets up the
// segment, the normalizer shifts the vector left by 8, 4, 2 or 1 bits a cycle
// (fewer shifts for long segments), the CORDIC unit then runs CORDIC_STEPS
// iterations, the offsets are rounded, the first vertex is loaded, and each
// vertex then waits in the output register until the output takes it. A lone
// point or a zero-length segment skips the normalizer and the CORDIC, and a
// point that is only held is taken without the block leaving its idle state.
// Configuration (thickness at index 0, vertex color at index 1) is written
// through the plain write port and must only change while the block is idle.

module polyline_to_triangle_strip #(
    parameter int FRAC_BITS    = ptts_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = ptts_pkg::CORDIC_STEPS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [ptts_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ptts_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  ptts_pkg::point_t               in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output ptts_pkg::vertex_t              out_data
);
    import ptts_pkg::*;

    // The controller and the datapath talk only through these two structs.
    ptts_cmd_t    cmd;
    ptts_status_t status;

    // The state machine decides when to accept, iterate and emit.
    ptts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // The datapath holds the point, the configuration, the CORDIC engine and
    // the output register that drives out_data.
    ptts_dp #(
        .FRAC_BITS    (FRAC_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .out_data  (out_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

/* verif/polyline_to_triangle_strip_test.sv */
// Self-checking testbench for polyline_to_triangle_strip: random and directed polylines
// are driven as requests, and every strip vertex is checked against a local predictor.
// Depends on ptts_pkg and the polyline_to_triangle_strip RTL.
`timescale 1ns / 1ps

module polyline_to_triangle_strip_test;

    import ptts_pkg::*;

    // Cycles allowed after the last expected vertex before the block counts as idle.
    // A held point causes no vertex, so the block may still be busy when the
    // queue of expected vertices runs dry.
    localparam int SETTLE_CYCLES = 48;
    // Random items per configuration phase; six phases plus the directed part
    // give about 270 requests.
    localparam int PHASE_ITEMS = 42;
    localparam longint NORM_CAP = longint'(1) <<< NORM_LOG2;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    point_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    vertex_t out_data;

    // Predictor copy of the configuration and of the held point.
    logic [31:0] thick_cfg = THICKNESS_RST;
    logic [31:0] color_cfg = COLOR_RST;
    longint held_x = 0;
    longint held_y = 0;
    bit have_held = 1'b0;

    // Points waiting to be driven, and the vertices the block still owes us.
    point_t pending_points[$];
    vertex_t strip_vertices[$];
    int issued_count = 0;
    int accepted_count = 0;
    int error_count = 0;

    // Idle bookkeeping for both sides: a wait drawn per item, and a counter
    // for stretches in which no waits are inserted at all.
    int in_gap_left = 0;
    int in_quiet = 0;
    int out_gap_left = 0;
    int out_quiet = 0;

    polyline_to_triangle_strip u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Rounds a value carrying FRAC_BITS guard bits to a whole Q16.16 LSB, half up.
    function automatic longint round_to_lsb(input longint v);
        return (v + (longint'(1) <<< (FRAC_BITS_DEF - 1))) >>> FRAC_BITS_DEF;
    endfunction

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647)
        begin
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sd2147483648)
        begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // Half-thickness offset for a segment (dx, dy). A vectoring CORDIC drives the
    // segment onto the x axis, while a companion vector that starts at (h/K, 0)
    // turns the opposite way and ends at h*(cos t, sin t). Then tx = h*sin t and
    // ty = h*cos t. A zero-length segment has angle zero and an exact offset.
    function automatic void segment_offset(input longint dx, input longint dy,
                                           output longint tx, output longint ty);
        longint x;
        longint y;
        longint cx;
        longint cy;
        longint nx;
        longint ny;
        longint ncx;
        longint ncy;
        longint unsigned gain_prod;
        x = dx;
        y = dy;
        cy = 0;
        if (dx == 0 && dy == 0)
        begin
            tx = 0;
            ty = round_to_lsb(longint'({32'd0, thick_cfg}) <<< (FRAC_BITS_DEF - 1));
            return;
        end
        // h/K with FRAC_BITS guard bits: thickness * (1/K in Q0.32), halved.
        gain_prod = {32'd0, thick_cfg};
        gain_prod = gain_prod * {32'd0, KINV_Q32};
        cx = longint'(gain_prod >> (33 - FRAC_BITS_DEF));
        // A left-pointing segment is turned by half a circle first, so the
        // companion starts on the negative x axis.
        if (x < 0)
        begin
            x = -x;
            y = -y;
            cx = -cx;
        end
        while ((x < 0 ? -x : x) < NORM_CAP && (y < 0 ? -y : y) < NORM_CAP)
        begin
            x = x + x;
            y = y + y;
        end
        for (int i = 0; i < CORDIC_STEPS_DEF; i++)
        begin
            if (y >= 0)
            begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                ncx = cx - (cy >>> i);
                ncy = cy + (cx >>> i);
            end
            else
            begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                ncx = cx + (cy >>> i);
                ncy = cy - (cx >>> i);
            end
            x = nx;
            y = ny;
            cx = ncx;
            cy = ncy;
        end
        tx = round_to_lsb(cy);
        ty = round_to_lsb(cx);
    endfunction

    // Queues the two strip vertices of one point: side 0 at (x+tx, y-ty) and
    // side 1 at (x-tx, y+ty). Only side 1 of the closing point ends the strip.
    function automatic void queue_pair(input longint px, input longint py,
                                       input longint tx, input longint ty,
                                       input bit closing);
        vertex_t v;
        v.vertex_x = clamp32(px + tx);
        v.vertex_y = clamp32(py - ty);
        v.color_out = color_cfg;
        v.side = 1'b0;
        v.last_vertex = 1'b0;
        strip_vertices.push_back(v);
        v.vertex_x = clamp32(px - tx);
        v.vertex_y = clamp32(py + ty);
        v.side = 1'b1;
        v.last_vertex = closing;
        strip_vertices.push_back(v);
    endfunction

    // Advances the predictor by one accepted point.
    function automatic void extrude_point(input point_t p);
        longint px;
        longint py;
        longint tx;
        longint ty;
        px = p.point_x;
        py = p.point_y;
        if (have_held)
        begin
            segment_offset(px - held_x, py - held_y, tx, ty);
            queue_pair(held_x, held_y, tx, ty, 1'b0);
            if (p.last_point)
            begin
                // The closing point reuses the offset of the segment into it.
                queue_pair(px, py, tx, ty, 1'b1);
                have_held = 1'b0;
                held_x = 0;
                held_y = 0;
            end
            else
            begin
                held_x = px;
                held_y = py;
            end
        end
        else if (p.last_point)
        begin
            // A lone point is drawn as if its segment had angle zero.
            segment_offset(0, 0, tx, ty);
            queue_pair(px, py, tx, ty, 1'b1);
        end
        else
        begin
            held_x = px;
            held_y = py;
            have_held = 1'b1;
        end
    endfunction

    // Draws the wait before the next item of one side, with now and then a
    // stretch of items that get no wait at all.
    function automatic int draw_wait(inout int quiet_left);
        if (quiet_left > 0)
        begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            quiet_left = $urandom_range(8, 24);
        end
        return $urandom_range(0, 5);
    endfunction

    // Compares one accepted vertex with the oldest expectation.
    function automatic void check_vertex(input vertex_t got);
        vertex_t want;
        if (strip_vertices.size() == 0)
        begin
            error_count++;
            if (error_count <= 10)
            begin
                $display("unexpected vertex x=%h y=%h color=%h side=%0d last=%0d",
                         got.vertex_x, got.vertex_y, got.color_out, got.side,
                         got.last_vertex);
            end
            return;
        end
        want = strip_vertices.pop_front();
        if (got.vertex_x !== want.vertex_x || got.vertex_y !== want.vertex_y ||
            got.color_out !== want.color_out || got.side !== want.side ||
            got.last_vertex !== want.last_vertex)
        begin
            error_count++;
            if (error_count <= 10)
            begin
                $display("vertex mismatch: expected x=%h y=%h color=%h side=%0d last=%0d",
                         want.vertex_x, want.vertex_y, want.color_out, want.side,
                         want.last_vertex);
                $display("                 actual   x=%h y=%h color=%h side=%0d last=%0d",
                         got.vertex_x, got.vertex_y, got.color_out, got.side,
                         got.last_vertex);
            end
        end
    endfunction

    // Request driver. A point is presented after its drawn wait and held with
    // valid high until the block takes it; the next one may follow at once.
    always @(posedge clk)
    begin : point_driver
        logic valid_next;
        valid_next = in_valid;
        if (!rst_n)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                extrude_point(in_data);
                accepted_count++;
                valid_next = 1'b0;
            end
            if (!valid_next)
            begin
                if (in_gap_left > 0)
                begin
                    in_gap_left--;
                end
                else if (pending_points.size() > 0)
                begin
                    in_data <= pending_points.pop_front();
                    valid_next = 1'b1;
                    in_gap_left = draw_wait(in_quiet);
                end
            end
        end
        in_valid <= valid_next;
    end

    // Vertex monitor. Each accepted vertex is checked, then ready drops for a
    // drawn number of cycles, so stalls land on every phase of the output.
    always @(posedge clk)
    begin : vertex_monitor
        logic ready_next;
        ready_next = out_ready;
        if (!rst_n)
        begin
            ready_next = 1'b0;
        end
        else if (out_valid && out_ready)
        begin
            check_vertex(out_data);
            out_gap_left = draw_wait(out_quiet);
            ready_next = (out_gap_left == 0);
        end
        else if (!out_ready)
        begin
            if (out_gap_left > 0)
            begin
                out_gap_left--;
            end
            ready_next = (out_gap_left == 0);
        end
        out_ready <= ready_next;
    end

    task automatic push_point(input logic [31:0] x, input logic [31:0] y, input logic last);
        point_t p;
        p.point_x = x;
        p.point_y = y;
        p.last_point = last;
        pending_points.push_back(p);
        issued_count++;
    endtask

    // Registers are written only while the block is idle, so the predictor's
    // copy can change right away.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_THICKNESS)
        begin
            thick_cfg = value;
        end
        else
        begin
            color_cfg = value;
        end
    endtask

    // Waits until every pushed point has been taken and every vertex has come,
    // then lets the block finish any work that produces no vertex.
    task automatic wait_drained();
        while (accepted_count != issued_count || strip_vertices.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_coord(input int style, input logic [31:0] prev);
        case (style)
            0:
            begin
                // A short step from the previous point, up to 16 units each way.
                return prev + ($urandom() & 32'h001F_FFFF) - 32'h0010_0000;
            end
            1:
            begin
                return $urandom();
            end
            default:
            begin
                case ($urandom_range(0, 4))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    3: return 32'hFFFF_FFFF;
                    default: return 32'h0000_0001;
                endcase
            end
        endcase
    endfunction

    // Most of a phase is well-formed polylines of random content: short walks,
    // wide jumps and corner points, plus lone points. The rest is noise with
    // random last_point bits, which also leaves points held across phases.
    task automatic push_random_phase(input int count);
        int made;
        int kind;
        int npts;
        int style;
        logic [31:0] x;
        logic [31:0] y;
        logic last;
        made = 0;
        while (made < count)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 5)
            begin
                npts = $urandom_range(2, 8);
                style = 0;
            end
            else if (kind == 8)
            begin
                npts = 1;
                style = 1;
            end
            else
            begin
                npts = $urandom_range(1, 4);
                style = (kind == 7) ? 2 : 1;
            end
            x = ($urandom_range(0, 1) == 0) ? $urandom() : ($urandom() & 32'h00FF_FFFF);
            y = ($urandom_range(0, 1) == 0) ? $urandom() : ($urandom() & 32'h00FF_FFFF);
            for (int k = 0; k < npts; k++)
            begin
                // Walks sometimes repeat a point to make a zero-length segment.
                if (style != 0 || (k > 0 && $urandom_range(0, 7) != 0))
                begin
                    x = pick_coord(style, x);
                    y = pick_coord(style, y);
                end
                if (kind == 9)
                begin
                    last = $urandom_range(0, 1);
                end
                else
                begin
                    last = (k == npts - 1);
                end
                push_point(x, y, last);
                made++;
            end
        end
    endtask

    initial
    begin : stimulus
        logic [31:0] thick_val;
        logic [31:0] color_val;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part under the reset configuration.
        // Lone points at the origin and at both corners, where the sums saturate.
        push_point(32'h0000_0000, 32'h0000_0000, 1'b1);
        push_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
        push_point(32'h8000_0000, 32'h8000_0000, 1'b1);
        // A plain rightward segment.
        push_point(32'h0000_0000, 32'h0000_0000, 1'b0);
        push_point(32'h000A_0000, 32'h0000_0000, 1'b1);
        // A left-pointing segment, a zero-length one, then a closing segment.
        push_point(32'h0010_0000, 32'h0010_0000, 1'b0);
        push_point(32'hFFFB_0000, 32'h0003_0000, 1'b0);
        push_point(32'hFFFB_0000, 32'h0003_0000, 1'b0);
        push_point(32'h0002_0000, 32'hFFF0_0000, 1'b1);
        // Straight up, then straight down.
        push_point(32'h0000_0000, 32'h0000_0000, 1'b0);
        push_point(32'h0000_0000, 32'h0005_0000, 1'b0);
        push_point(32'h0000_0000, 32'h0000_0000, 1'b1);
        // Corner to corner, the widest segments the fields allow.
        push_point(32'h8000_0000, 32'h8000_0000, 1'b0);
        push_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        push_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        push_point(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
        // Segments whose components are at most one LSB long.
        push_point(32'h0000_0000, 32'h0000_0000, 1'b0);
        push_point(32'h0000_0001, 32'h0000_0000, 1'b0);
        push_point(32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
        wait_drained();

        // Random phases, each under its own configuration.
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:
                begin
                    thick_val = 32'h0000_0000;
                    color_val = 32'h0000_0000;
                end
                1:
                begin
                    thick_val = 32'hFFFF_FFFF;
                    color_val = 32'hFFFF_FFFF;
                end
                2:
                begin
                    thick_val = 32'h0002_0000;
                    color_val = $urandom();
                end
                3:
                begin
                    thick_val = $urandom();
                    color_val = $urandom();
                end
                4:
                begin
                    thick_val = $urandom_range(0, 32'h0010_0000);
                    color_val = $urandom();
                end
                default:
                begin
                    thick_val = THICKNESS_RST;
                    color_val = COLOR_RST;
                end
            endcase
            write_reg(CFG_THICKNESS, thick_val);
            write_reg(CFG_COLOR, color_val);
            push_random_phase(PHASE_ITEMS);
            wait_drained();
        end

        if (error_count == 0 && strip_vertices.size() == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin : watchdog
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

/* sim.f */
src/ptts_pkg.sv
src/ptts_ctrl.sv
src/ptts_dp.sv
src/polyline_to_triangle_strip.sv
verif/polyline_to_triangle_strip_test.sv
